FILE: rtl/dgc_pkg.sv
// dimmer gesture control package: word types, state type, scaling constants
// and the divide-by-4095 helper used by the rule stage
// no dependencies
`timescale 1ns / 1ps

package dgc_pkg;

	// configuration register indexes
	localparam logic CFG_MIN_LEVEL = 1'b0;
	localparam logic CFG_MAX_LEVEL = 1'b1;

	// reset values
	localparam logic [7:0]  MIN_LEVEL_RST    = 8'd1;
	localparam logic [7:0]  MAX_LEVEL_RST    = 8'd255;
	localparam logic [10:0] BLINK_PERIOD_RST = 11'd1000;
	localparam logic [6:0]  FADE_PERIOD_RST  = 7'd12;

	// mapping constants
	localparam logic [10:0] BLINK_LO      = 11'd200;
	localparam logic [10:0] BLINK_HI      = 11'd2000;
	localparam logic [10:0] BLINK_SPAN    = 11'd1800;
	localparam logic [6:0]  FADE_LO       = 7'd8;
	localparam logic [3:0]  FADE_SPAN     = 4'd10;
	localparam logic [6:0]  FADE_TOP_STEP = 7'd17;
	localparam logic [6:0]  FADE_SLOWEST  = 7'd64;

	// input word
	typedef struct packed {
		logic        short_press;
		logic        long_press;
		logic        double_click;
		logic        triple_click;
		logic [11:0] pot_reading;
	} dgc_item_t;

	// result word
	typedef struct packed {
		logic [7:0]  level;
		logic        blinking;
		logic [10:0] blink_period;
		logic [6:0]  fade_period;
	} dgc_result_t;

	// per-led state
	typedef struct packed {
		logic [7:0]  level;
		logic        blink_on;
		logic        tune_level;
		logic        tune_blink;
		logic        tune_fade;
		logic [10:0] blink_period;
		logic [6:0]  fade_period;
	} dgc_state_t;

	// gestures plus the undivided products of the three linear maps
	typedef struct packed {
		logic        short_press;
		logic        long_press;
		logic        double_click;
		logic        triple_click;
		logic        level_desc;
		logic [19:0] level_prod;
		logic [22:0] blink_prod;
		logic [15:0] fade_prod;
	} dgc_prod_t;

	// floor(x / 4095), exact while the quotient stays below 2048
	function automatic logic [10:0] div_pot_full(input logic [22:0] x);
		logic [23:0] sum;
		sum = {1'b0, x} + {13'd0, x[22:12]} + 24'd1;
		return sum[22:12];
	endfunction

endpackage

FILE: rtl/led_dimmer_gesture_control_unit.sv
// dimmer gesture control top level: configuration registers, product
// register, state and result register; uses dgc_pkg, dgc_scale, dgc_rules
`timescale 1ns / 1ps

// Takes one gesture word per clock and returns one result word per word
// taken, in order. The first register holds the gestures with the pot
// products (one 12x8 multiply and two constant multiplies), the second is
// the result register, loaded together with the led state after the
// divide-by-4095 and the gesture rules. The input side stalls only while
// both registers are full and the result is stalled. min_level and
// max_level are written through the plain write port while idle; the user
// must keep to this, as the block itself does not enforce it.
module led_dimmer_gesture_control_unit import dgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  dgc_item_t   item_word,
	output logic        result_valid,
	input  logic        result_stall,
	output dgc_result_t result_word
);

	logic [7:0]  min_level_q;
	logic [7:0]  max_level_q;
	logic        valid_s1;
	dgc_prod_t   prod_s1;
	dgc_prod_t   prod;
	dgc_state_t  state_q;
	dgc_state_t  next_state;
	dgc_result_t result_q;
	logic        advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= MIN_LEVEL_RST;
			max_level_q <= MAX_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_LEVEL: min_level_q <= cfg_data;
				CFG_MAX_LEVEL: max_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign advance    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !advance;

	// products of the incoming word
	dgc_scale u_scale (
		.item      (item_word),
		.min_level (min_level_q),
		.max_level (max_level_q),
		.prod      (prod)
	);

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			prod_s1 <= prod;
		end
	end

	// divide and gesture rules
	dgc_rules u_rules (
		.prod       (prod_s1),
		.state      (state_q),
		.min_level  (min_level_q),
		.max_level  (max_level_q),
		.next_state (next_state)
	);

	// led state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{level: 8'd0, blink_on: 1'b0, tune_level: 1'b0,
			             tune_blink: 1'b0, tune_fade: 1'b0,
			             blink_period: BLINK_PERIOD_RST, fade_period: FADE_PERIOD_RST};
		end else if (valid_s1 && advance) begin
			state_q <= next_state;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q.level        <= next_state.level;
			result_q.blinking     <= next_state.blink_on;
			result_q.blink_period <= next_state.blink_period;
			result_q.fade_period  <= next_state.fade_period;
		end
	end

	assign result_word = result_q;

	// at most one tuning mode at a time
	a_one_tuning: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({state_q.tune_level, state_q.tune_blink, state_q.tune_fade}))
		else $error("more than one tuning mode active");

	// blink interval stays within its range
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.blink_period >= BLINK_LO) && (state_q.blink_period <= BLINK_HI))
		else $error("blink period out of range");

	// fade interval is a fast step or the slowest setting
	a_fade_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q.fade_period >= FADE_LO) && (state_q.fade_period <= FADE_TOP_STEP))
		|| (state_q.fade_period == FADE_SLOWEST))
		else $error("fade period out of range");

	// state changes only when a word moves into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("led state changed without a word");

endmodule

FILE: rtl/dgc_scale.sv
// dimmer gesture control product stage: multiplies the pot sample, or its
// complement, by the span of each linear map; uses dgc_pkg
`timescale 1ns / 1ps

module dgc_scale import dgc_pkg::*; (
	input  dgc_item_t  item,
	input  logic [7:0] min_level,
	input  logic [7:0] max_level,
	output dgc_prod_t  prod
);

	logic [7:0]  level_mag;
	logic        level_desc;
	logic [11:0] pot_inv;

	// magnitude and direction of the brightness span
	always_comb begin
		level_desc = min_level > max_level;
		level_mag  = level_desc ? (min_level - max_level) : (max_level - min_level);
	end

	// 4095 - pot is the bitwise complement of a 12-bit value
	assign pot_inv = ~item.pot_reading;

	// products, divided later
	always_comb begin
		prod.short_press  = item.short_press;
		prod.long_press   = item.long_press;
		prod.double_click = item.double_click;
		prod.triple_click = item.triple_click;
		prod.level_desc   = level_desc;
		prod.level_prod   = {8'd0, item.pot_reading} * {12'd0, level_mag};
		prod.blink_prod   = {11'd0, pot_inv} * {12'd0, BLINK_SPAN};
		prod.fade_prod    = {4'd0, pot_inv} * {12'd0, FADE_SPAN};
	end

endmodule

FILE: rtl/dgc_rules.sv
// dimmer gesture control rule stage: finishes the linear maps and applies
// the gesture rules in order to give the next state; uses dgc_pkg
`timescale 1ns / 1ps

module dgc_rules import dgc_pkg::*; (
	input  dgc_prod_t  prod,
	input  dgc_state_t state,
	input  logic [7:0] min_level,
	input  logic [7:0] max_level,
	output dgc_state_t next_state
);

	logic [10:0] level_q;
	logic [10:0] blink_q;
	logic [10:0] fade_q;
	logic [7:0]  tuned_level;
	logic [10:0] tuned_blink;
	logic [6:0]  fade_raw;
	logic [6:0]  tuned_fade;

	// divide each product by 4095
	always_comb begin
		level_q = div_pot_full({3'd0, prod.level_prod});
		blink_q = div_pot_full(prod.blink_prod);
		fade_q  = div_pot_full({7'd0, prod.fade_prod});
	end

	// mapped values; the brightness map stays between the two limits
	always_comb begin
		tuned_level = prod.level_desc ? (min_level - level_q[7:0])
		                              : (min_level + level_q[7:0]);
		tuned_blink = blink_q + BLINK_LO;
		fade_raw    = {3'd0, fade_q[3:0]} + FADE_LO;
		tuned_fade  = (fade_raw > FADE_TOP_STEP) ? FADE_SLOWEST : fade_raw;
	end

	// gesture rules, each seeing the state left by the previous one
	always_comb begin
		next_state = state;
		if (prod.short_press) begin
			next_state.tune_level = 1'b0;
			next_state.tune_blink = 1'b0;
			next_state.tune_fade  = 1'b0;
			if (!next_state.blink_on) begin
				next_state.level = (next_state.level != max_level) ? max_level : 8'd0;
			end else begin
				next_state.blink_on = 1'b0;
				next_state.level    = max_level;
			end
		end
		if (prod.long_press) begin
			if (!next_state.tune_level) begin
				next_state.tune_blink = 1'b0;
				next_state.tune_fade  = 1'b0;
				next_state.blink_on   = 1'b0;
				next_state.tune_level = 1'b1;
			end else begin
				next_state.tune_level = 1'b0;
				next_state.tune_blink = 1'b0;
				next_state.tune_fade  = 1'b0;
				next_state.level      = 8'd0;
			end
		end
		if (next_state.tune_level) begin
			next_state.level = tuned_level;
		end
		// blink start from either multi-click
		if (prod.double_click || prod.triple_click) begin
			next_state.tune_level = 1'b0;
			next_state.tune_blink = 1'b0;
			next_state.tune_fade  = 1'b0;
			if (!next_state.blink_on) begin
				if (next_state.level == 8'd0) begin
					next_state.level = max_level;
				end
				next_state.blink_on = 1'b1;
			end
		end
		if (prod.double_click) begin
			next_state.tune_blink = 1'b1;
		end
		if (next_state.tune_blink) begin
			next_state.blink_period = tuned_blink;
		end
		// triple click wins over double click
		if (prod.triple_click) begin
			next_state.tune_blink = 1'b0;
			next_state.tune_fade  = 1'b1;
		end
		if (next_state.tune_fade) begin
			next_state.fade_period = tuned_fade;
		end
	end

endmodule

FILE: tb/sv/dimmer_scoreboard_pkg.sv
// scoreboard for the dimmer gesture control: predicts the led state word by word
// and checks result words in order; depends on dgc_pkg
`timescale 1ns / 1ps

package dimmer_scoreboard_pkg;
	import dgc_pkg::*;

	localparam int POT_FULL = 4095;

	class dimmer_scoreboard;
		// copy of the limit registers
		logic [7:0]  min_lvl;
		logic [7:0]  max_lvl;
		// predicted led state
		logic [7:0]  lvl;
		bit          blink_on;
		bit          tune_lvl;
		bit          tune_blink;
		bit          tune_fade;
		logic [10:0] blink_ms;
		logic [6:0]  fade_step;
		// results still owed by the block, oldest first
		dgc_result_t due_results[$];
		int          errors;
		int          words_taken;
		int          results_seen;

		function new();
			min_lvl = MIN_LEVEL_RST;
			max_lvl = MAX_LEVEL_RST;
			lvl = 8'd0;
			blink_on = 1'b0;
			leave_tuning();
			blink_ms = BLINK_PERIOD_RST;
			fade_step = FADE_PERIOD_RST;
			errors = 0;
			words_taken = 0;
			results_seen = 0;
		endfunction

		function void set_limit(logic idx, logic [7:0] val);
			if (idx == CFG_MIN_LEVEL) begin
				min_lvl = val;
			end else begin
				max_lvl = val;
			end
		endfunction

		function void leave_tuning();
			tune_lvl = 1'b0;
			tune_blink = 1'b0;
			tune_fade = 1'b0;
		endfunction

		// gesture rules in their fixed order, each seeing the state left by the last
		function dgc_result_t apply_gestures(dgc_item_t w);
			int pot;
			int inv;
			int span;
			int fade;
			dgc_result_t r;
			pot = int'(w.pot_reading);
			inv = POT_FULL - pot;

			// short press: toggle, or stop blinking at full brightness
			if (w.short_press) begin
				leave_tuning();
				if (!blink_on) begin
					lvl = (lvl != max_lvl) ? max_lvl : 8'd0;
				end else begin
					blink_on = 1'b0;
					lvl = max_lvl;
				end
			end

			// long press: enter brightness tuning, or leave it and go dark
			if (w.long_press) begin
				if (!tune_lvl) begin
					leave_tuning();
					blink_on = 1'b0;
					tune_lvl = 1'b1;
				end else begin
					leave_tuning();
					lvl = 8'd0;
				end
			end

			// brightness map, signed span so inverted limits descend
			if (tune_lvl) begin
				span = int'(max_lvl) - int'(min_lvl);
				lvl = 8'((pot * span) / POT_FULL + int'(min_lvl));
			end

			// any multi-click starts blinking, lighting a dark led
			if (w.double_click || w.triple_click) begin
				leave_tuning();
				if (!blink_on) begin
					if (lvl == 8'd0) begin
						lvl = max_lvl;
					end
					blink_on = 1'b1;
				end
			end

			if (w.double_click) begin
				leave_tuning();
				tune_blink = 1'b1;
			end

			if (tune_blink) begin
				blink_ms = 11'((inv * int'(BLINK_SPAN)) / POT_FULL + int'(BLINK_LO));
			end

			if (w.triple_click) begin
				leave_tuning();
				tune_fade = 1'b1;
			end

			// fade map, top step folded onto the slowest setting
			if (tune_fade) begin
				fade = (inv * int'(FADE_SPAN)) / POT_FULL + int'(FADE_LO);
				if (fade > int'(FADE_TOP_STEP)) begin
					fade = int'(FADE_SLOWEST);
				end
				fade_step = 7'(fade);
			end

			r.level = lvl;
			r.blinking = blink_on;
			r.blink_period = blink_ms;
			r.fade_period = fade_step;
			return r;
		endfunction

		function void take_word(dgc_item_t w);
			due_results.push_back(apply_gestures(w));
			words_taken++;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(dgc_result_t got);
			dgc_result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				$display("%0t: result word with none outstanding, expected nothing, got %p",
					$time, got);
				errors++;
			end else begin
				want = due_results.pop_front();
				compare_field("level", want.level, got.level);
				compare_field("blinking", want.blinking, got.blinking);
				compare_field("blink_period", want.blink_period, got.blink_period);
				compare_field("fade_period", want.fade_period, got.fade_period);
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/tb.sv
// top-level bench for led_dimmer_gesture_control_unit: directed and random
// gesture words under random stalls, across several limit settings
// depends on dgc_pkg and dimmer_scoreboard_pkg
`timescale 1ns / 1ps

module tb;
	import dgc_pkg::*;
	import dimmer_scoreboard_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        item_valid;
	logic        item_stall;
	dgc_item_t   item_word;
	logic        result_valid;
	logic        result_stall;
	dgc_result_t result_word;

	dimmer_scoreboard sb;
	bit quiet;
	int gap_odds;
	int stall_odds;
	int words_sent;
	int limit_sets;

	led_dimmer_gesture_control_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_word(item_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word(result_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// result side stalls in random bursts
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 99) < stall_odds) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// check every result word taken
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result_word);
		end
	end

	function automatic dgc_item_t gesture(bit sp, bit lp, bit dc, bit tc, logic [11:0] pot);
		dgc_item_t w;
		w.short_press = sp;
		w.long_press = lp;
		w.double_click = dc;
		w.triple_click = tc;
		w.pot_reading = pot;
		return w;
	endfunction

	// pot sample biased towards the ends of the range
	function automatic logic [11:0] pot_sample();
		case ($urandom_range(0, 7))
			0: return 12'd0;
			1: return 12'd4095;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// offer one word, with an optional gap first, and wait for it to be taken
	task automatic send_word(input dgc_item_t w);
		if (!quiet && $urandom_range(0, 99) < gap_odds) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_word <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.take_word(w);
		words_sent++;
	endtask

	// hold off the sender until every result is back, then let the pipe settle
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(input logic [7:0] lo, input logic [7:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_LEVEL;
		cfg_data <= lo;
		@(posedge clk);
		sb.set_limit(CFG_MIN_LEVEL, lo);
		cfg_index <= CFG_MAX_LEVEL;
		cfg_data <= hi;
		@(posedge clk);
		sb.set_limit(CFG_MAX_LEVEL, hi);
		cfg_we <= 1'b0;
		limit_sets++;
	endtask

	// mostly tuning sessions with random pot sweeps, some stray gesture mixes
	task automatic random_run(input int count);
		int target;
		int steps;
		target = words_sent + count;
		while (words_sent < target) begin
			steps = $urandom_range(1, 8);
			case ($urandom_range(0, 7))
				0, 1: begin
					send_word(gesture(0, 1, 0, 0, pot_sample()));
					repeat (steps) send_word(gesture(0, 0, 0, 0, pot_sample()));
					send_word(gesture(1'($urandom_range(0, 1)), 1, 0, 0, pot_sample()));
				end
				2, 3: begin
					send_word(gesture(0, 0, 1, 0, pot_sample()));
					repeat (steps) send_word(gesture(0, 0, 0, 0, pot_sample()));
				end
				4: begin
					send_word(gesture(0, 0, 0, 1, pot_sample()));
					repeat (steps) send_word(gesture(0, 0, 0, 0, pot_sample()));
				end
				5: send_word(gesture(1, 0, 0, 0, pot_sample()));
				6: send_word(gesture(0, 0, 0, 0, pot_sample()));
				default: send_word(dgc_item_t'({4'($urandom), pot_sample()}));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_LEVEL;
		cfg_data = 8'd0;
		item_valid = 1'b0;
		item_word = '0;
		quiet = 1'b0;
		gap_odds = 25;
		stall_odds = 25;
		words_sent = 0;
		limit_sets = 1;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset limits
		send_word(gesture(0, 0, 0, 0, 12'd0));
		send_word(gesture(1, 0, 0, 0, 12'd0));
		send_word(gesture(1, 0, 0, 0, 12'd0));
		send_word(gesture(0, 1, 0, 0, 12'd4095));
		send_word(gesture(0, 0, 0, 0, 12'd0));
		send_word(gesture(0, 0, 0, 0, 12'd2048));
		send_word(gesture(0, 1, 0, 0, 12'd100));
		// blink start while dark, then the blink map at both ends
		send_word(gesture(0, 0, 1, 0, 12'd0));
		send_word(gesture(0, 0, 0, 0, 12'd4095));
		// fade map: pot zero folds onto the slowest step
		send_word(gesture(0, 0, 0, 1, 12'd0));
		send_word(gesture(0, 0, 0, 0, 12'd4095));
		send_word(gesture(0, 0, 0, 0, 12'd1));
		send_word(gesture(1, 0, 0, 0, 12'd300));
		// double and triple click together
		send_word(gesture(0, 0, 1, 1, 12'd0));
		send_word(gesture(0, 1, 0, 0, 12'd1234));
		send_word(gesture(1, 1, 0, 0, 12'd3000));
		send_word(gesture(0, 1, 1, 0, 12'd500));
		send_word(gesture(1, 1, 1, 1, 12'd4095));
		send_word(gesture(1, 0, 1, 0, 12'd2047));
		send_word(gesture(0, 1, 0, 1, 12'd4094));
		send_word(gesture(1, 0, 0, 0, 12'hAAA));
		send_word(gesture(0, 0, 0, 0, 12'h555));
		random_run(100);

		// further limit settings, inverted and zero ones among them
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: write_limits(8'd0, 8'd255);
				1: write_limits(8'd255, 8'd0);
				2: write_limits(8'd200, 8'd40);
				3: write_limits(8'd0, 8'd0);
				4: write_limits(8'd255, 8'd255);
				default: write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
			endcase
			gap_odds = $urandom_range(0, 40);
			stall_odds = $urandom_range(0, 40);
			quiet = (phase == 5);
			if (phase == 1) begin
				random_run(50);
				drain();
				random_run(50);
			end else begin
				random_run(100);
			end
		end

		drain();
		$display("summary: %0d gesture words taken, %0d result words checked, %0d limit settings",
			sb.words_taken, sb.results_seen, limit_sets);
		if (sb.pending() != 0) begin
			$display("%0t: %0d result words never arrived", $time, sb.pending());
		end
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
